[sv/triangular_distribution_unit_top_defines.svh]
// Assertion helpers for the checker file.
`ifndef TRIANGULAR_DISTRIBUTION_UNIT_TOP_DEFINES_SVH
`define TRIANGULAR_DISTRIBUTION_UNIT_TOP_DEFINES_SVH

// Implication checked only outside reset.
`define TDU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked also during reset.
`define TDU_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[sv/tdu_pkg.sv]
package tdu_pkg;

   typedef enum logic [1:0] {
      CUM_ZERO,
      CUM_LEFT,
      CUM_RIGHT,
      CUM_ONE
   } cum_class_type;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   localparam int REG_LOW  = 0;
   localparam int REG_MODE = 1;
   localparam int REG_HIGH = 2;

   // One classified item as it travels from the front end to the back end.
   typedef struct packed {
      logic          err;
      logic [15:0]   a;
      logic [15:0]   b;
      logic          dzero;
      logic [15:0]   dnum;
      logic [31:0]   dden;
      cum_class_type cclass;
      logic [31:0]   csq;
      logic [31:0]   cden;
      logic          sleft;
      logic [47:0]   srad;
   } entry_type;

endpackage

[sv/triangular_distribution_unit_top.sv]
// Triangular distribution unit. Program the lower bound a, the mode c and the
// upper bound b through the csr port while the unit is idle. Every request
// transfer carries a point x and a uniform draw u (Q0.16); every response
// transfer returns the density at x (Q0.32, saturating at all ones), the
// cumulative probability at x (Q1.16, 65536 means one) and an inverse-CDF
// sample taken from u, rounded down. When the bounds are inconsistent (not
// a < b with a <= c <= b) the error flag in rsp_tuser is set and all three
// results are zero. The unit accepts one request per clock cycle and keeps
// that rate as long as responses are taken. A request passes through the
// front end (classification and the multiplies), a small queue and then the
// back end, whose length is set by the 32-step restoring divide for the
// density; the cumulative divide and the square root share the first
// sixteen of those steps.
module triangular_distribution_unit_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_value[15:0], uniform_draw[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // density[31:0], cumulative[48:32],
                                    // sample[64:49], zeros above
   output logic [0:0]  rsp_tuser,   // config_error[0]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] low_bound_ff, mode_point_ff, high_bound_ff;

   logic               f_valid;
   tdu_pkg::entry_type f_entry;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;
   tdu_pkg::entry_type q_entry;
   logic               b_err;

   // Configuration registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_bound_ff  <= 16'd0;
         mode_point_ff <= 16'd32768;
         high_bound_ff <= 16'd65535;
      end else if (csr_we) begin
         case (csr_index)
            2'(tdu_pkg::REG_LOW):  low_bound_ff  <= csr_wdata;
            2'(tdu_pkg::REG_MODE): mode_point_ff <= csr_wdata;
            2'(tdu_pkg::REG_HIGH): high_bound_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The front end classifies each point against the segments and forms
   // the divisors and the radicand before handing the item to the queue.
   tdu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .low_bound    (low_bound_ff),
      .mode_point   (mode_point_ff),
      .high_bound   (high_bound_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .x_value      (req_tdata[15:0]),
      .uniform_draw (req_tdata[31:16]),
      .out_valid    (f_valid),
      .out_full     (q_full),
      .out_entry    (f_entry)
   );

   tdu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_valid),
      .push_entry (f_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head_entry (q_entry)
   );

   // The back end runs the divides and the square root as a stall-able
   // pipeline that ends in the response register.
   tdu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_entry   (q_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_err   (b_err)
   );

   assign rsp_tuser = b_err;

endmodule

[sv/tdu_front.sv]
module tdu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        low_bound,
   input  logic [15:0]        mode_point,
   input  logic [15:0]        high_bound,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [15:0]        x_value,
   input  logic [15:0]        uniform_draw,
   output logic               out_valid,
   input  logic               out_full,
   output tdu_pkg::entry_type out_entry
);

   typedef struct packed {
      logic                   valid;
      logic                   err;
      logic [15:0]            a;
      logic [15:0]            b;
      logic [15:0]            w;
      logic [15:0]            l;
      logic [15:0]            r;
      logic                   dleft;
      logic                   dzero;
      logic [15:0]            dnum;
      tdu_pkg::cum_class_type cclass;
      logic [15:0]            cbase;
      logic [15:0]            u;
   } f1_type;

   typedef struct packed {
      logic                   valid;
      logic                   err;
      logic [15:0]            a;
      logic [15:0]            b;
      logic [15:0]            l;
      logic [15:0]            r;
      logic                   dleft;
      logic                   dzero;
      logic [15:0]            dnum;
      tdu_pkg::cum_class_type cclass;
      logic [31:0]            wl;
      logic [31:0]            wr;
      logic [31:0]            csq;
      logic [31:0]            uw;
      logic [31:0]            uc;
   } f2_type;

   f1_type f1_ff, f1_in;
   f2_type f2_ff, f2_in;
   logic   f3_valid_ff;
   tdu_pkg::entry_type f3_ff, f3_in;
   logic   advance;
   logic [32:0] uc_full;

   assign advance   = !f3_valid_ff || !out_full;
   assign in_ready  = advance;
   assign out_valid = f3_valid_ff;
   assign out_entry = f3_ff;

   always_comb begin
      f1_in.valid = in_valid;
      f1_in.err   = !((low_bound < high_bound) && (low_bound <= mode_point)
                      && (mode_point <= high_bound));
      f1_in.a     = low_bound;
      f1_in.b     = high_bound;
      f1_in.w     = high_bound - low_bound;
      f1_in.l     = mode_point - low_bound;
      f1_in.r     = high_bound - mode_point;
      f1_in.u     = uniform_draw;
      f1_in.dzero = (x_value < low_bound) || (x_value > high_bound);
      f1_in.dleft = (x_value <= mode_point) && (mode_point != low_bound);
      f1_in.dnum  = f1_in.dleft ? (x_value - low_bound) : (high_bound - x_value);
      f1_in.cbase = (x_value < mode_point) ? (x_value - low_bound)
                                           : (high_bound - x_value);
      if (x_value < low_bound) begin
         f1_in.cclass = tdu_pkg::CUM_ZERO;
      end else if (x_value < mode_point) begin
         f1_in.cclass = tdu_pkg::CUM_LEFT;
      end else if ((x_value <= high_bound) && (high_bound != mode_point)) begin
         f1_in.cclass = tdu_pkg::CUM_RIGHT;
      end else begin
         f1_in.cclass = tdu_pkg::CUM_ONE;
      end
   end

   always_comb begin
      uc_full     = ({16'h0, tdu_pkg::ONE_Q16 - {1'b0, f1_ff.u}})
                    * {17'h0, f1_ff.w};
      f2_in.valid = f1_ff.valid;
      f2_in.err   = f1_ff.err;
      f2_in.a     = f1_ff.a;
      f2_in.b     = f1_ff.b;
      f2_in.l     = f1_ff.l;
      f2_in.r     = f1_ff.r;
      f2_in.dleft = f1_ff.dleft;
      f2_in.dzero = f1_ff.dzero;
      f2_in.dnum  = f1_ff.dnum;
      f2_in.cclass = f1_ff.cclass;
      f2_in.wl    = {16'h0, f1_ff.w} * {16'h0, f1_ff.l};
      f2_in.wr    = {16'h0, f1_ff.w} * {16'h0, f1_ff.r};
      f2_in.csq   = {16'h0, f1_ff.cbase} * {16'h0, f1_ff.cbase};
      f2_in.uw    = {16'h0, f1_ff.u} * {16'h0, f1_ff.w};
      f2_in.uc    = uc_full[31:0];
   end

   always_comb begin
      f3_in.err    = f2_ff.err;
      f3_in.a      = f2_ff.a;
      f3_in.b      = f2_ff.b;
      f3_in.dzero  = f2_ff.dzero;
      f3_in.dnum   = f2_ff.dnum;
      f3_in.dden   = f2_ff.dleft ? f2_ff.wl : f2_ff.wr;
      f3_in.cclass = f2_ff.cclass;
      f3_in.csq    = f2_ff.csq;
      f3_in.cden   = (f2_ff.cclass == tdu_pkg::CUM_LEFT) ? f2_ff.wl : f2_ff.wr;
      f3_in.sleft  = ({16'h0, f2_ff.uw} <= {16'h0, f2_ff.l, 16'h0});
      f3_in.srad   = f3_in.sleft ? ({16'h0, f2_ff.uw} * {32'h0, f2_ff.l})
                                 : ({16'h0, f2_ff.uc} * {32'h0, f2_ff.r});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff.valid <= 1'b0;
         f2_ff.valid <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_ff       <= f1_in;
         f2_ff       <= f2_in;
         f3_valid_ff <= f2_ff.valid;
         f3_ff       <= f3_in;
      end
   end

endmodule

[sv/tdu_queue.sv]
module tdu_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tdu_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output tdu_pkg::entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tdu_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[sv/tdu_back.sv]
module tdu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   output logic               q_pop,
   input  tdu_pkg::entry_type q_entry,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [71:0]        out_data,
   output logic               out_err
);

   localparam int STEPS = 32;

   typedef struct packed {
      logic                   valid;
      logic                   err;
      logic [15:0]            a;
      logic [15:0]            b;
      logic                   dzero;
      logic                   dsat;
      logic [31:0]            dden;
      logic [32:0]            rem_d;
      logic [31:0]            q_d;
      tdu_pkg::cum_class_type cclass;
      logic [31:0]            cden;
      logic [32:0]            rem_c;
      logic [16:0]            q_c;
      logic                   sleft;
      logic [31:0]            rad;
      logic [18:0]            srem;
      logic [15:0]            root;
      logic                   low_nz;
   } bk_type;

   // One restoring step of the density divide; the first sixteen steps also
   // advance the cumulative divide and the square root by one digit.
   function automatic bk_type bk_step(bk_type s, logic narrow);
      bk_type      n;
      logic [32:0] t;
      logic [32:0] tc;
      logic [18:0] t2;
      logic [18:0] trial;
      logic        ge;
      logic        gec;
      logic        ge2;
      n     = s;
      t     = {s.rem_d[31:0], 1'b0};
      ge    = t >= {1'b0, s.dden};
      n.rem_d = ge ? (t - {1'b0, s.dden}) : t;
      n.q_d   = {s.q_d[30:0], ge};
      tc    = {s.rem_c[31:0], 1'b0};
      gec   = tc >= {1'b0, s.cden};
      t2    = {s.srem[16:0], s.rad[31:30]};
      trial = {1'b0, s.root, 2'b01};
      ge2   = t2 >= trial;
      if (narrow) begin
         n.rem_c = gec ? (tc - {1'b0, s.cden}) : tc;
         n.q_c   = {s.q_c[15:0], gec};
         n.srem  = ge2 ? (t2 - trial) : t2;
         n.root  = {s.root[14:0], ge2};
         n.rad   = {s.rad[29:0], 2'b00};
      end
      return n;
   endfunction

   bk_type bk_ff [STEPS+1];
   bk_type bk_in [STEPS+1];
   logic        out_valid_ff;
   logic [71:0] out_data_ff;
   logic        out_err_ff;
   logic [71:0] out_data_in;
   logic        advance;
   logic [32:0] two_d;
   logic        q16;
   logic [31:0] dens;
   logic [16:0] cum;
   logic [15:0] samp;
   logic [16:0] kup;
   logic [16:0] cq;

   assign advance   = !out_valid_ff || out_ready;
   assign q_pop     = advance && !q_empty;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_err   = out_err_ff;

   always_comb begin
      two_d = {16'h0, q_entry.dnum, 1'b0};
      q16   = {1'b0, q_entry.csq} >= {1'b0, q_entry.cden};
      bk_in[0].valid  = q_pop;
      bk_in[0].err    = q_entry.err;
      bk_in[0].a      = q_entry.a;
      bk_in[0].b      = q_entry.b;
      bk_in[0].dzero  = q_entry.dzero;
      bk_in[0].dsat   = two_d >= {1'b0, q_entry.dden};
      bk_in[0].dden   = q_entry.dden;
      bk_in[0].rem_d  = two_d;
      bk_in[0].q_d    = '0;
      bk_in[0].cclass = q_entry.cclass;
      bk_in[0].cden   = q_entry.cden;
      bk_in[0].rem_c  = q16 ? {1'b0, q_entry.csq - q_entry.cden} : {1'b0, q_entry.csq};
      bk_in[0].q_c    = {16'h0, q16};
      bk_in[0].sleft  = q_entry.sleft;
      bk_in[0].rad    = q_entry.srad[47:16];
      bk_in[0].srem   = '0;
      bk_in[0].root   = '0;
      bk_in[0].low_nz = |q_entry.srad[15:0];
      for (int i = 1; i <= STEPS; i++) begin
         bk_in[i] = bk_step(bk_ff[i-1], i <= 16);
      end
   end

   always_comb begin
      if (bk_ff[STEPS].dzero) begin
         dens = '0;
      end else if (bk_ff[STEPS].dsat) begin
         dens = '1;
      end else begin
         dens = bk_ff[STEPS].q_d;
      end
      cq = bk_ff[STEPS].q_c + 17'(bk_ff[STEPS].rem_c != '0);
      case (bk_ff[STEPS].cclass)
         tdu_pkg::CUM_ZERO:  cum = '0;
         tdu_pkg::CUM_LEFT:  cum = bk_ff[STEPS].q_c;
         tdu_pkg::CUM_RIGHT: cum = tdu_pkg::ONE_Q16 - cq;
         default:            cum = tdu_pkg::ONE_Q16;
      endcase
      kup = {1'b0, bk_ff[STEPS].root}
            + 17'((bk_ff[STEPS].srem != '0) || bk_ff[STEPS].low_nz);
      samp = bk_ff[STEPS].sleft ? (bk_ff[STEPS].a + bk_ff[STEPS].root)
                                : (bk_ff[STEPS].b - kup[15:0]);
      if (bk_ff[STEPS].err) begin
         out_data_in = '0;
      end else begin
         out_data_in = {7'h0, samp, cum, dens};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STEPS; i++) begin
            bk_ff[i].valid <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i <= STEPS; i++) begin
            bk_ff[i] <= bk_in[i];
         end
         out_valid_ff <= bk_ff[STEPS].valid;
         out_data_ff  <= out_data_in;
         out_err_ff   <= bk_ff[STEPS].err;
      end
   end

endmodule

[sv/tdu_checker.sv]
`include "triangular_distribution_unit_top_defines.svh"

module tdu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        csr_we,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_wdata
);

   // A stalled response transfer keeps its payload.
   `TDU_ASSERT_NEXT(a_rsp_hold, clock, !reset && rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // An error response carries all-zero results.
   `TDU_ASSERT_IMP(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == 72'h0)

   // The cumulative probability never exceeds one and padding stays zero.
   `TDU_ASSERT_IMP(a_cum_range, clock, reset, rsp_tvalid, rsp_tdata[48:32] <= 17'h10000 && rsp_tdata[71:65] == 7'h0)

   // No response is offered right after reset.
   `TDU_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_tvalid)

endmodule

bind triangular_distribution_unit_top tdu_checker u_tdu_checker (.*);
